>>> rtl/epoch_seconds_to_calendar_unit_macros.svh
// Assertion macros shared by the calendar conversion RTL.
// Expects clk and rst_n in the scope of each use.
`ifndef EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH
`define EPOCH_SECONDS_TO_CALENDAR_UNIT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ESC_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off during reset.
`define ESC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/esc_pkg.sv
// Package for the calendar conversion block: payload types, division
// reciprocals and calendar constants. No dependencies.
`timescale 1ns / 1ps
package esc_pkg;

  // Reciprocals: x/15 = (x*MAGIC_DIV15)>>35, x/3 = (x*MAGIC_DIV3)>>33 (32-bit x),
  // x/1461 = (x*MAGIC_DIV1461)>>27 for x below 94519.
  localparam logic [31:0] MAGIC_DIV15   = 32'h8888_8889;
  localparam logic [31:0] MAGIC_DIV3    = 32'hAAAA_AAAB;
  localparam logic [16:0] MAGIC_DIV1461 = 17'd91868;

  // Count days from 1968-01-01 in four-year blocks that open with a leap year.
  localparam logic [15:0] EPOCH_BIAS    = 16'd731;
  // Day index of 2100-03-01; from here on skip the missing Feb 29 of 2100.
  localparam logic [15:0] SKIP_LEAP_DAY = 16'd47541;
  localparam logic [15:0] DAYS_PER_4Y   = 16'd1461;
  localparam logic [11:0] BASE_YEAR     = 12'd1968;
  localparam logic [10:0] YEAR1_START   = 11'd366;
  localparam logic [10:0] YEAR2_START   = 11'd731;
  localparam logic [10:0] YEAR3_START   = 11'd1096;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } hms_t;

  typedef struct packed {
    logic [15:0] days;
    hms_t        hms;
  } tod_t;

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    hms_t        hms;
  } cal_t;

  // Day of year on which month idx+1 starts (idx 0 is January).
  function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
    logic [8:0] base;
    unique case (idx)
      4'd0:    base = 9'd0;
      4'd1:    base = 9'd31;
      4'd2:    base = 9'd59;
      4'd3:    base = 9'd90;
      4'd4:    base = 9'd120;
      4'd5:    base = 9'd151;
      4'd6:    base = 9'd181;
      4'd7:    base = 9'd212;
      4'd8:    base = 9'd243;
      4'd9:    base = 9'd273;
      4'd10:   base = 9'd304;
      4'd11:   base = 9'd334;
      default: base = 9'd0;
    endcase
    return base + ((leap && idx >= 4'd2) ? 9'd1 : 9'd0);
  endfunction

endpackage

>>> rtl/esc_if.sv
// Channel interfaces of the calendar conversion block: valid/ready plus payload.
// Depends on nothing.
`timescale 1ns / 1ps
interface esc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] epoch_seconds;

  modport source (output valid, output epoch_seconds, input ready);
  modport sink   (input valid, input epoch_seconds, output ready);
endinterface

interface esc_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;

  modport source (output valid, output year, output month, output day,
                  output hour, output minute, output second, input ready);
  modport sink   (input valid, input year, input month, input day,
                  input hour, input minute, input second, output ready);
endinterface

>>> rtl/epoch_seconds_to_calendar_unit.sv
// Top level: seconds since 1970-01-01 00:00:00 to Gregorian date and time.
// Uses esc_pkg, esc_in_if/esc_out_if, esc_tod and esc_date.
//
// Usage:
//   in_ch  (sink)   : one item = 32-bit unsigned epoch_seconds.
//   out_ch (source) : one item = year, month, day, hour, minute, second.
//   Every accepted item yields exactly one result, in order.
// Timing:
//   Ten register stages: four for the time-of-day split (two reciprocal
//   multiply/remainder steps by 60, one by 24) and six for the date (bias
//   and 2100 fix-up, divide and remainder by 1461 days, year, month, day).
//   One item per cycle when nothing stalls.
// Reset:
//   rst_n (synchronous, low) clears the stage valid bits only; no state is
//   kept between items, so nothing else needs clearing.
// Backpressure:
//   When out_ch.ready is low the last stage holds its item; earlier stages
//   keep filling any empty slots, and in_ch.ready drops only once every
//   stage holds an item. Nothing is lost or repeated.
`timescale 1ns / 1ps
module epoch_seconds_to_calendar_unit (
  input  logic      clk,
  input  logic      rst_n,
  esc_in_if.sink    in_ch,
  esc_out_if.source out_ch
);
  import esc_pkg::*;

  // link between the time-of-day and the date sections
  logic tod_valid;
  logic tod_ready;
  tod_t tod_data;
  cal_t cal_data;

  // Split seconds, minutes, hours; leave whole days.
  esc_tod u_tod (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ch.ready),
    .in_seconds (in_ch.epoch_seconds),
    .out_valid  (tod_valid),
    .out_ready  (tod_ready),
    .out_tod    (tod_data)
  );

  // Walk the days into year, month and day of month.
  esc_date u_date (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (tod_valid),
    .in_ready  (tod_ready),
    .in_tod    (tod_data),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_cal   (cal_data)
  );

  // Unpack the result onto the output channel.
  assign out_ch.year   = cal_data.year;
  assign out_ch.month  = cal_data.month;
  assign out_ch.day    = cal_data.day;
  assign out_ch.hour   = cal_data.hms.hour;
  assign out_ch.minute = cal_data.hms.minute;
  assign out_ch.second = cal_data.hms.second;

endmodule

>>> rtl/esc_tod.sv
// Time-of-day split: seconds into second, minute, hour and whole days.
// Four register stages; uses esc_pkg and the assertion macro header.
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_unit_macros.svh"
module esc_tod (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [31:0]   in_seconds,
  output logic          out_valid,
  input  logic          out_ready,
  output esc_pkg::tod_t out_tod
);
  import esc_pkg::*;

  localparam int NSTG = 4;

  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   adv;

  // stage A
  logic [61:0] prod_in;
  logic [31:0] x_a_r;
  logic [26:0] q60_a_r;
  // stage B
  logic [31:0] rem60_a;
  logic [56:0] prod_a;
  logic [5:0]  sec_b_r;
  logic [26:0] q60_b_r;
  logic [20:0] q3600_b_r;
  // stage C
  logic [26:0] rem60_b;
  logic [49:0] prod_b;
  logic [5:0]  sec_c_r;
  logic [5:0]  min_c_r;
  logic [20:0] q3600_c_r;
  logic [15:0] days_c_r;
  // stage D
  logic [20:0] rem24_c;
  logic [5:0]  sec_d_r;
  logic [5:0]  min_d_r;
  logic [4:0]  hr_d_r;
  logic [15:0] days_d_r;

  // A stage moves when it is empty or the one after it moves.
  always_comb begin
    adv[NSTG] = out_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // x/60 = (x/4)/15
  assign prod_in = 62'(in_seconds[31:2]) * 62'(MAGIC_DIV15);
  assign rem60_a = x_a_r - (32'(q60_a_r) * 32'd60);
  assign prod_a  = 57'(q60_a_r[26:2]) * 57'(MAGIC_DIV15);
  assign rem60_b = q60_b_r - (27'(q3600_b_r) * 27'd60);
  // x/24 = (x/8)/3
  assign prod_b  = 50'(q3600_b_r[20:3]) * 50'(MAGIC_DIV3);
  assign rem24_c = q3600_c_r - (21'(days_c_r) * 21'd24);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      x_a_r   <= in_seconds;
      q60_a_r <= prod_in[61:35];
    end
    if (adv[1]) begin
      sec_b_r   <= rem60_a[5:0];
      q60_b_r   <= q60_a_r;
      q3600_b_r <= prod_a[55:35];
    end
    if (adv[2]) begin
      sec_c_r   <= sec_b_r;
      min_c_r   <= rem60_b[5:0];
      q3600_c_r <= q3600_b_r;
      days_c_r  <= prod_b[48:33];
    end
    if (adv[3]) begin
      sec_d_r  <= sec_c_r;
      min_d_r  <= min_c_r;
      hr_d_r   <= rem24_c[4:0];
      days_d_r <= days_c_r;
    end
  end

  assign out_valid          = vld_r[NSTG-1];
  assign out_tod.days       = days_d_r;
  assign out_tod.hms.hour   = hr_d_r;
  assign out_tod.hms.minute = min_d_r;
  assign out_tod.hms.second = sec_d_r;

  `ESC_ASSERT_IMPLY(a_tod_hour, out_valid, out_tod.hms.hour < 5'd24, "hour out of range")
  `ESC_ASSERT_IMPLY(a_tod_minute, out_valid, out_tod.hms.minute < 6'd60, "minute out of range")
  `ESC_ASSERT_IMPLY(a_tod_second, out_valid, out_tod.hms.second < 6'd60, "second out of range")

endmodule

>>> rtl/esc_date.sv
// Date stages: whole days into year, month and day of month; carries the
// time of day along. Six register stages; uses esc_pkg and the macro header.
`timescale 1ns / 1ps
`include "epoch_seconds_to_calendar_unit_macros.svh"
module esc_date (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  esc_pkg::tod_t in_tod,
  output logic          out_valid,
  input  logic          out_ready,
  output esc_pkg::cal_t out_cal
);
  import esc_pkg::*;

  localparam int NSTG = 6;

  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   adv;
  hms_t            hms_r [NSTG];

  logic [15:0] adj_in;
  logic [15:0] d0_r;
  logic [32:0] prod_0;
  logic [15:0] d1_r;
  logic [5:0]  cyc1_r;
  logic [15:0] rem_1;
  logic [10:0] r2_r;
  logic [5:0]  cyc2_r;
  logic [1:0]  yoff_2;
  logic [10:0] doy_2;
  logic [11:0] year3_r;
  logic [8:0]  doy3_r;
  logic        leap3_r;
  logic [3:0]  mon_3;
  logic [11:0] year4_r;
  logic [8:0]  doy4_r;
  logic        leap4_r;
  logic [3:0]  mon4_r;
  logic [8:0]  day_4;
  logic [11:0] year5_r;
  logic [3:0]  mon5_r;
  logic [4:0]  day5_r;

  always_comb begin
    adv[NSTG] = out_ready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      adv[i] = !vld_r[i] || adv[i+1];
    end
  end

  assign in_ready = adv[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (adv[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (adv[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  // Pretend 2100 is a leap year: shift every day from its March 1 by one.
  assign adj_in = in_tod.days + ((in_tod.days >= SKIP_LEAP_DAY) ? 16'd1 : 16'd0)
                  + EPOCH_BIAS;
  assign prod_0 = 33'(d0_r) * 33'(MAGIC_DIV1461);
  assign rem_1  = d1_r - (16'(cyc1_r) * DAYS_PER_4Y);

  // Year within the four-year block; the first one is the leap year.
  always_comb begin
    priority if (r2_r >= YEAR3_START) begin
      yoff_2 = 2'd3;
      doy_2  = r2_r - YEAR3_START;
    end else if (r2_r >= YEAR2_START) begin
      yoff_2 = 2'd2;
      doy_2  = r2_r - YEAR2_START;
    end else if (r2_r >= YEAR1_START) begin
      yoff_2 = 2'd1;
      doy_2  = r2_r - YEAR1_START;
    end else begin
      yoff_2 = 2'd0;
      doy_2  = r2_r;
    end
  end

  // Month: the last month whose first day is not past the day of year.
  always_comb begin
    mon_3 = 4'd1;
    for (int k = 1; k < 12; k++) begin
      if (doy3_r >= month_start(4'(k), leap3_r)) begin
        mon_3 = 4'(k + 1);
      end
    end
  end

  assign day_4 = doy4_r - month_start(mon4_r - 4'd1, leap4_r) + 9'd1;

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d0_r     <= adj_in;
      hms_r[0] <= in_tod.hms;
    end
    if (adv[1]) begin
      d1_r     <= d0_r;
      cyc1_r   <= prod_0[32:27];
      hms_r[1] <= hms_r[0];
    end
    if (adv[2]) begin
      r2_r     <= rem_1[10:0];
      cyc2_r   <= cyc1_r;
      hms_r[2] <= hms_r[1];
    end
    if (adv[3]) begin
      year3_r  <= BASE_YEAR + 12'({cyc2_r, 2'b00}) + 12'(yoff_2);
      doy3_r   <= doy_2[8:0];
      leap3_r  <= (yoff_2 == 2'd0);
      hms_r[3] <= hms_r[2];
    end
    if (adv[4]) begin
      year4_r  <= year3_r;
      doy4_r   <= doy3_r;
      leap4_r  <= leap3_r;
      mon4_r   <= mon_3;
      hms_r[4] <= hms_r[3];
    end
    if (adv[5]) begin
      year5_r  <= year4_r;
      mon5_r   <= mon4_r;
      day5_r   <= day_4[4:0];
      hms_r[5] <= hms_r[4];
    end
  end

  assign out_valid     = vld_r[NSTG-1];
  assign out_cal.year  = year5_r;
  assign out_cal.month = mon5_r;
  assign out_cal.day   = day5_r;
  assign out_cal.hms   = hms_r[NSTG-1];

  `ESC_ASSERT_IMPLY(a_date_year, out_valid, out_cal.year >= 12'd1970 && out_cal.year <= 12'd2106, "year out of range")
  `ESC_ASSERT_IMPLY(a_date_month, out_valid, out_cal.month >= 4'd1 && out_cal.month <= 4'd12, "month out of range")
  `ESC_ASSERT_IMPLY(a_date_day, out_valid, out_cal.day >= 5'd1 && (out_cal.month != 4'd2 || out_cal.day <= 5'd29) && ((out_cal.month != 4'd4 && out_cal.month != 4'd6 && out_cal.month != 4'd9 && out_cal.month != 4'd11) || out_cal.day <= 5'd30), "day beyond month length")
  `ESC_ASSERT_NEXT(a_date_epoch, in_valid && in_ready && in_tod.days == 16'd0, vld_r[0] && d0_r == EPOCH_BIAS, "epoch day not biased into 1970")

endmodule

>>> dv/esc_calendar_checker.sv
// Scoreboard for the calendar conversion block: predicts each date and time
// from the accepted seconds and compares it with the result channel.
// Depends on esc_pkg and the esc_in_if / esc_out_if interfaces.
`timescale 1ns / 1ps
module esc_calendar_checker (
  input  logic clk,
  input  logic rst_n,
  esc_in_if    in_mon,
  esc_out_if   out_mon,
  output int   mismatch_count,
  output int   dates_pending
);
  import esc_pkg::*;

  cal_t expected_dates[$];

  function automatic bit gregorian_leap(input int unsigned yr);
    return ((yr % 4) == 0 && (yr % 100) != 0) || (yr % 400) == 0;
  endfunction

  // Split into time of day, then walk whole years and whole months.
  function automatic cal_t civil_from_epoch(input logic [31:0] secs);
    int unsigned t;
    int unsigned yr;
    int unsigned mon;
    int unsigned ylen;
    int unsigned mlen;
    cal_t        r;
    t = secs;
    r.hms.second = 6'(t % 60);
    t = t / 60;
    r.hms.minute = 6'(t % 60);
    t = t / 60;
    r.hms.hour = 5'(t % 24);
    t = t / 24;
    yr = 1970;
    ylen = gregorian_leap(yr) ? 366 : 365;
    while (t >= ylen) begin
      t = t - ylen;
      yr++;
      ylen = gregorian_leap(yr) ? 366 : 365;
    end
    mon = 1;
    while (mon < 12) begin
      if (mon == 2)
        mlen = gregorian_leap(yr) ? 29 : 28;
      else if (mon == 4 || mon == 6 || mon == 9 || mon == 11)
        mlen = 30;
      else
        mlen = 31;
      if (t < mlen)
        break;
      t = t - mlen;
      mon++;
    end
    r.year  = 12'(yr);
    r.month = 4'(mon);
    r.day   = 5'(t + 1);
    return r;
  endfunction

  task automatic report_field(input string name, input int unsigned exp_v,
                              input int unsigned act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    dates_pending  = 0;
  end

  always @(posedge clk) begin
    cal_t exp_d;
    if (rst_n) begin
      if (in_mon.valid && in_mon.ready)
        expected_dates.push_back(civil_from_epoch(in_mon.epoch_seconds));
      if (out_mon.valid && out_mon.ready) begin
        if (expected_dates.size() == 0) begin
          $display("%0t: unexpected result, expected none actual %0d-%0d-%0d %0d:%0d:%0d",
                   $realtime, out_mon.year, out_mon.month, out_mon.day,
                   out_mon.hour, out_mon.minute, out_mon.second);
          mismatch_count++;
        end else begin
          exp_d = expected_dates.pop_front();
          report_field("year",   exp_d.year,       out_mon.year);
          report_field("month",  exp_d.month,      out_mon.month);
          report_field("day",    exp_d.day,        out_mon.day);
          report_field("hour",   exp_d.hms.hour,   out_mon.hour);
          report_field("minute", exp_d.hms.minute, out_mon.minute);
          report_field("second", exp_d.hms.second, out_mon.second);
        end
      end
      dates_pending <= expected_dates.size();
    end
  end

endmodule

>>> dv/tb_top.sv
// Top of the calendar conversion testbench: clock, reset, seconds stimulus,
// result-side stalls, watchdog and verdict.
// Depends on esc_pkg, esc_if.sv, the block under test and esc_calendar_checker.
`timescale 1ns / 1ps
module tb_top;

  localparam int RANDOM_ITEMS   = 750;
  localparam int CALM_TAIL      = 100;   // last items sent with no idling
  localparam int WATCHDOG_LIMIT = 1000;  // cycles with no item moving
  localparam int DRAIN_CYCLES   = 20;    // pipeline is 10 deep

  logic clk;
  logic rst_n;
  int   mismatch_count;
  int   dates_pending;
  int   idle_pct;
  int   stuck_cycles;

  esc_in_if  in_ch ();
  esc_out_if out_ch ();

  epoch_seconds_to_calendar_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  esc_calendar_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_count),
    .dates_pending  (dates_pending)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Drive one item and hold it until the block takes it.
  task automatic send_epoch(input logic [31:0] secs);
    if ($urandom_range(0, 99) < idle_pct) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.epoch_seconds <= secs;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // Pick seconds that favor calendar edges: midnights, year starts, the end
  // of February, both ends of the range; a share stays uniform over 32 bits.
  function automatic logic [31:0] pick_epoch();
    longint      v;
    int unsigned yr;
    longint      days;
    case ($urandom_range(0, 9))
      0, 1, 2, 3: v = $urandom;
      4, 5: begin
        days = $urandom_range(0, 49709);
        case ($urandom_range(0, 2))
          0: v = days * 86400;
          1: v = days * 86400 + 86399;
          default: v = days * 86400 + $urandom_range(0, 86399);
        endcase
      end
      6, 7: begin
        yr = $urandom_range(1971, 2106);
        // Leap days before yr: 1972, 1976, ... except 2100.
        days = longint'(yr - 1970) * 365 + (yr - 1969) / 4 - ((yr > 2100) ? 1 : 0);
        // Jan 1, Feb 28 or the next two days, give or take a few seconds.
        case ($urandom_range(0, 3))
          0: days = days + 0;
          1: days = days + 58;
          2: days = days + 59;
          default: days = days + 60;
        endcase
        v = days * 86400 + longint'($urandom_range(0, 4)) - 2;
      end
      8: v = $urandom_range(0, 100000);
      default: v = 64'hFFFF_FFFF - $urandom_range(0, 100000);
    endcase
    if (v < 0)
      v = 0;
    if (v > 64'hFFFF_FFFF)
      v = 64'hFFFF_FFFF;
    return v[31:0];
  endfunction

  // Stimulus and verdict.
  initial begin
    logic [31:0] directed_epochs[];
    directed_epochs = '{
      32'd0,            // epoch itself
      32'hFFFF_FFFF,    // last second the field can hold
      32'd59,           // second rolls to minute
      32'd3599,         // minute rolls to hour
      32'd86399,        // last second of the first day
      32'd31535999,     // last second of a common year
      32'd68169600,     // leap day of a common leap year
      32'd68255999,     // last second of that leap day
      32'd946684799,    // last second of a century year's eve
      32'd951782400,    // leap day of a year divisible by 400
      32'd978307199,    // last day of a leap year, day 366
      32'd1483228799,   // last second of another leap year
      32'd4107455999,   // last second of Feb 27 in a century year with no leap day
      32'd4107542400,   // Mar 1 of that century year
      32'd4133894400,   // first second of the last day of that century year
      32'hAAAA_AAAA,
      32'h5555_5555,
      32'h8000_0000,
      32'h7FFF_FFFF
    };
    rst_n               = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.epoch_seconds = '0;
    out_ch.ready        = 1'b0;
    idle_pct            = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idle_pct = 20;
    foreach (directed_epochs[i])
      send_epoch(directed_epochs[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Change the idling mix every 64 items; drop it for the tail.
      if (n >= RANDOM_ITEMS - CALM_TAIL)
        idle_pct = 0;
      else if (n % 64 == 0)
        case ($urandom_range(0, 3))
          0: idle_pct = 0;
          1: idle_pct = 10;
          2: idle_pct = 30;
          default: idle_pct = 60;
        endcase
      send_epoch(pick_epoch());
    end
    in_ch.valid <= 1'b0;

    // Wait for every predicted date, then let the pipeline settle.
    while (dates_pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && dates_pending == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  // Result side: stall in bursts at the current idling rate.
  initial begin
    repeat (4) @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < idle_pct) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: count cycles in which no item moves on either channel.
  initial stuck_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      stuck_cycles <= 0;
    else
      stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

endmodule

>>> epoch_seconds_to_calendar_unit.f
+incdir+rtl
rtl/esc_pkg.sv
rtl/esc_if.sv
rtl/esc_tod.sv
rtl/esc_date.sv
rtl/epoch_seconds_to_calendar_unit.sv
dv/esc_calendar_checker.sv
dv/tb_top.sv
